>>> hw/rtl/r5a3g_pkg.sv
`default_nettype none

package r5a3g_pkg;

    // Item modes
    localparam logic [1:0] MODE_TEXEL = 2'd0;
    localparam logic [1:0] MODE_RGB8  = 2'd1;
    localparam logic [1:0] MODE_S16   = 2'd2;

    // Luma weights, sized for the signed product width
    localparam int unsigned PROD_W = 25;
    localparam int unsigned LUMA_W = PROD_W - 8;
    localparam logic signed [PROD_W-1:0] LUMA_WR = 25'sd77;
    localparam logic signed [PROD_W-1:0] LUMA_WG = 25'sd150;
    localparam logic signed [PROD_W-1:0] LUMA_WB = 25'sd29;

    // Clamp limits for the signed mode
    localparam logic signed [LUMA_W-1:0] GRAY_MIN = -17'sd1024;
    localparam logic signed [LUMA_W-1:0] GRAY_MAX = 17'sd1023;

    // Expand a 5-bit channel to 8 bits: x*255/31 = 8x + floor(7x/31)
    function automatic logic [7:0] expand5(input logic [4:0] x);
        logic [7:0]  seven_x;
        logic [15:0] scaled;
        begin
            seven_x = {3'b000, x} * 8'd7;
            scaled  = {8'h00, seven_x} * 16'd265;
            expand5 = {x, 3'b000} + {5'b00000, scaled[15:13]};
        end
    endfunction

    // Requantise an 8-bit luma to 5 bits: floor(l*31/255)
    function automatic logic [4:0] quant5(input logic [7:0] l);
        logic [12:0] prod;
        logic [12:0] acc;
        begin
            prod   = {5'b00000, l} * 13'd31;
            acc    = prod + {8'h00, prod[12:8]} + 13'd1;
            quant5 = acc[12:8];
        end
    endfunction

    // Requantise an 8-bit luma to 4 bits: floor((l+8)/17)
    function automatic logic [3:0] quant4(input logic [7:0] l);
        logic [8:0]  biased;
        logic [15:0] prod;
        begin
            biased = {1'b0, l} + 9'd8;
            prod   = {7'h00, biased} * 16'd241;
            quant4 = prod[15:12];
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rgb5a3_grayscale_converter_top.sv
`default_nettype none

// Grey-scale converter for RGB5A3 texels and RGB colours.
// Input channel: in_valid/in_ready carry mode, texel_in and red/green/blue_in.
// Mode 0 converts an RGB5A3 texel into a grey texel of the same format
// (opaque and translucent layouts both handled), mode 1 returns the luma of
// an unsigned 8-bit colour, mode 2 returns the floored luma of signed 16-bit
// channels clamped to -1024..1023. Mode 3 yields zeros.
// Output channel: out_valid/out_ready carry texel_out and gray_out; the
// field unused by the mode is zero.
// Pipeline: four register stages (channel expansion, weight multipliers,
// sum and shift, requantise/clamp into the output register); the first
// stage loads at the accepting edge itself, and out_valid rises once the
// item reaches the output register.
// Throughput: one item per cycle unless stalled; each stage advances when
// it is empty or the stage after it advances; bubbles close up during a stall.
// When out_ready is low the output register holds its item and the stages
// behind it fill; in_ready falls only once every stage is occupied.
// Reset clears all valid bits; the block is empty and ready afterwards.
module rgb5a3_grayscale_converter_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic [15:0]        texel_in,
    input  wire logic signed [15:0] red_in,
    input  wire logic signed [15:0] green_in,
    input  wire logic signed [15:0] blue_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             texel_out,
    output logic signed [10:0]      gray_out
);

    localparam int unsigned PW = r5a3g_pkg::PROD_W;
    localparam int unsigned LW = r5a3g_pkg::LUMA_W;

    // Valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // Stage 1: expanded channels
    logic [1:0]         s1_mode_reg;
    logic               s1_opaque_reg;
    logic [2:0]         s1_alpha_reg;
    logic signed [15:0] s1_r_reg, s1_g_reg, s1_b_reg;
    logic signed [15:0] s1_r_next, s1_g_next, s1_b_next;

    // Stage 2: weighted products
    logic [1:0]           s2_mode_reg;
    logic                 s2_opaque_reg;
    logic [2:0]           s2_alpha_reg;
    logic signed [PW-1:0] s2_pr_reg, s2_pg_reg, s2_pb_reg;

    // Stage 3: luma
    logic [1:0]           s3_mode_reg;
    logic                 s3_opaque_reg;
    logic [2:0]           s3_alpha_reg;
    logic signed [LW-1:0] s3_lum_reg;
    logic signed [PW-1:0] sum_next;

    // Stage 4: output register
    logic [15:0]        texel_reg, texel_next;
    logic signed [10:0] gray_reg, gray_next;
    logic [4:0]         q5;
    logic [3:0]         q4;

    // Advance a stage when it is empty or the one after it advances
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Expand channels to a common signed form
    always_comb
    begin
        case (mode)
            r5a3g_pkg::MODE_TEXEL:
            begin
                if (texel_in[15])
                begin
                    s1_r_next = {8'h00, r5a3g_pkg::expand5(texel_in[14:10])};
                    s1_g_next = {8'h00, r5a3g_pkg::expand5(texel_in[9:5])};
                    s1_b_next = {8'h00, r5a3g_pkg::expand5(texel_in[4:0])};
                end
                else
                begin
                    s1_r_next = {8'h00, texel_in[11:8], texel_in[11:8]};
                    s1_g_next = {8'h00, texel_in[7:4], texel_in[7:4]};
                    s1_b_next = {8'h00, texel_in[3:0], texel_in[3:0]};
                end
            end
            r5a3g_pkg::MODE_RGB8:
            begin
                s1_r_next = {8'h00, red_in[7:0]};
                s1_g_next = {8'h00, green_in[7:0]};
                s1_b_next = {8'h00, blue_in[7:0]};
            end
            default:
            begin
                s1_r_next = red_in;
                s1_g_next = green_in;
                s1_b_next = blue_in;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_mode_reg   <= mode;
            s1_opaque_reg <= texel_in[15];
            s1_alpha_reg  <= texel_in[14:12];
            s1_r_reg      <= s1_r_next;
            s1_g_reg      <= s1_g_next;
            s1_b_reg      <= s1_b_next;
        end
    end

    // Multiply by the luma weights
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_opaque_reg <= s1_opaque_reg;
            s2_alpha_reg  <= s1_alpha_reg;
            s2_pr_reg     <= PW'(s1_r_reg) * r5a3g_pkg::LUMA_WR;
            s2_pg_reg     <= PW'(s1_g_reg) * r5a3g_pkg::LUMA_WG;
            s2_pb_reg     <= PW'(s1_b_reg) * r5a3g_pkg::LUMA_WB;
        end
    end

    // Sum and floor-shift by 8
    assign sum_next = s2_pr_reg + s2_pg_reg + s2_pb_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_mode_reg   <= s2_mode_reg;
            s3_opaque_reg <= s2_opaque_reg;
            s3_alpha_reg  <= s2_alpha_reg;
            s3_lum_reg    <= sum_next[PW-1:8];
        end
    end

    // Requantise, repack or clamp
    assign q5 = r5a3g_pkg::quant5(s3_lum_reg[7:0]);
    assign q4 = r5a3g_pkg::quant4(s3_lum_reg[7:0]);

    always_comb
    begin
        texel_next = 16'h0000;
        gray_next  = 11'sd0;
        case (s3_mode_reg)
            r5a3g_pkg::MODE_TEXEL:
            begin
                if (s3_opaque_reg)
                    texel_next = {1'b1, q5, q5, q5};
                else
                    texel_next = {1'b0, s3_alpha_reg, q4, q4, q4};
            end
            r5a3g_pkg::MODE_RGB8:
            begin
                gray_next = {3'b000, s3_lum_reg[7:0]};
            end
            r5a3g_pkg::MODE_S16:
            begin
                if (s3_lum_reg < r5a3g_pkg::GRAY_MIN)
                    gray_next = r5a3g_pkg::GRAY_MIN[10:0];
                else if (s3_lum_reg > r5a3g_pkg::GRAY_MAX)
                    gray_next = r5a3g_pkg::GRAY_MAX[10:0];
                else
                    gray_next = s3_lum_reg[10:0];
            end
            default:
            begin
                texel_next = 16'h0000;
                gray_next  = 11'sd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            texel_reg <= texel_next;
            gray_reg  <= gray_next;
        end
    end

    assign out_valid = v4_reg;
    assign texel_out = texel_reg;
    assign gray_out  = gray_reg;

endmodule

`default_nettype wire
